FILE: hdl/tilt_balance_pd_controller_defines.svh
// ---------------------------------------------------------------------------
// tilt balance controller assertion macros
// shared property wrappers, sampled on clk with rst_n low masking checks
// ---------------------------------------------------------------------------
`ifndef TILT_BALANCE_PD_CONTROLLER_DEFINES_SVH
`define TILT_BALANCE_PD_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define TBPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tbpd_pkg.sv
// ---------------------------------------------------------------------------
// tbpd_pkg
// types, constants and helpers of the tilt balance pd controller
// ---------------------------------------------------------------------------
`default_nettype none

package tbpd_pkg;

  // cordic iteration count (8 to 24)
  localparam int CORDIC_STEPS = 16;
  // index width of the arctangent table (24 entries)
  localparam int CNT_W        = 5;
  // cordic datapath widths
  localparam int CXY_W        = 28;
  localparam int CZ_W         = 26;
  // shared multiplier widths
  localparam int MA_W         = 26;
  localparam int MB_W         = 25;
  localparam int PROD_W       = MA_W + MB_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int RND_W        = SUM_W - 16;
  localparam int SAT_W        = 38;

  localparam logic signed [CZ_W-1:0] DEG180  = 26'sd11796480;
  localparam logic signed [SAT_W-1:0] ANG_MAX = 38'sd16777215;
  localparam logic signed [SAT_W-1:0] ANG_MIN = -38'sd16777216;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MGYRO,
    ST_A1,
    ST_MBW,
    ST_MBA,
    ST_ANG,
    ST_MP,
    ST_MD,
    ST_DRV
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GYRO_OFFSET  = 3'd0,
    REG_GYRO_SCALE   = 3'd1,
    REG_BLEND_WEIGHT = 3'd2,
    REG_PROP_GAIN    = 3'd3,
    REG_DERIV_GAIN   = 3'd4,
    REG_TILT_LIMIT   = 3'd5,
    REG_DRIVE_LIMIT  = 3'd6
  } reg_idx_t;

  // atan(2^-i) in q9.16 degrees
  function automatic logic [21:0] atan_deg(input logic [CNT_W-1:0] i);
    logic [21:0] t;
    unique case (i)
      5'd0:    t = 22'd2949120;
      5'd1:    t = 22'd1740967;
      5'd2:    t = 22'd919879;
      5'd3:    t = 22'd466945;
      5'd4:    t = 22'd234379;
      5'd5:    t = 22'd117304;
      5'd6:    t = 22'd58666;
      5'd7:    t = 22'd29335;
      5'd8:    t = 22'd14668;
      5'd9:    t = 22'd7334;
      5'd10:   t = 22'd3667;
      5'd11:   t = 22'd1833;
      5'd12:   t = 22'd917;
      5'd13:   t = 22'd458;
      5'd14:   t = 22'd229;
      5'd15:   t = 22'd115;
      5'd16:   t = 22'd57;
      5'd17:   t = 22'd29;
      5'd18:   t = 22'd14;
      5'd19:   t = 22'd7;
      5'd20:   t = 22'd4;
      5'd21:   t = 22'd2;
      5'd22:   t = 22'd1;
      default: t = 22'd0;
    endcase
    return t;
  endfunction

  // shift right by 16 with round half up
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + SUM_W'(32768);
    return t[SUM_W-1:16];
  endfunction

  // saturate to a 25-bit angle
  function automatic logic signed [24:0] sat25(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] t;
    if (v > ANG_MAX) begin
      t = ANG_MAX;
    end else if (v < ANG_MIN) begin
      t = ANG_MIN;
    end else begin
      t = v;
    end
    return t[24:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tilt_balance_pd_controller.sv
// ---------------------------------------------------------------------------
// tilt_balance_pd_controller
// complementary-filter tilt estimate with a saturated pd drive output
// ---------------------------------------------------------------------------
// One sample is taken when in_tready is high; in_tready then stays low until
// the result is handed to the output register, so the block takes no new
// sample before it is through with the last one. The work is the cordic
// atan2 iterations on one shift-add unit followed by five passes through one
// shared 26 x 25 multiplier for gyro integration, the filter blend and the pd
// terms. The result sits in an output register, so the next sample may be
// taken while it waits; a finished result only holds the sequencer when the
// previous one has not been taken yet. Configuration writes are always
// accepted and are meant for idle periods.
`default_nettype none

module tilt_balance_pd_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  // sample input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // accel_lateral, accel_vertical, roll_rate
  // result output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // drive, tilt_angle, zero padding
  output logic             out_tuser   // upright
);

  // configuration registers
  logic signed [15:0] gyro_offset_r;
  logic [23:0]        gyro_scale_r;
  logic [15:0]        blend_weight_r;
  logic [15:0]        prop_gain_r;
  logic [15:0]        deriv_gain_r;
  logic [23:0]        tilt_limit_r;
  logic [16:0]        drive_limit_r;

  // sequencer and datapath registers
  tbpd_pkg::state_t                  state_r, state_nxt;
  logic [tbpd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [16:0]                rate_r, rate_nxt;
  logic signed [tbpd_pkg::CXY_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [tbpd_pkg::CZ_W-1:0]  cz_r, cz_nxt;
  logic                              zero_r, zero_nxt;
  logic signed [24:0]                a1_r, a1_nxt;
  logic signed [24:0]                angle_r, angle_nxt;
  logic signed [24:0]                est_r, est_nxt;
  logic signed [24:0]                last_err_r, last_err_nxt;
  logic                              up_r, up_nxt;
  logic signed [tbpd_pkg::PROD_W-1:0] prod_r, prod_nxt, sum_r, sum_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [17:0]                drive_r, drive_nxt;
  logic signed [24:0]                tilt_r, tilt_nxt;
  logic                              upright_r, upright_nxt;

  // combinational helpers
  logic signed [tbpd_pkg::MA_W-1:0]  mul_a;
  logic signed [tbpd_pkg::MB_W-1:0]  mul_b;
  logic signed [16:0]                in_ay, in_az, in_x0;
  logic signed [16:0]                cx0, cy0;
  logic signed [tbpd_pkg::CXY_W-1:0] sx, sy;
  logic signed [tbpd_pkg::CZ_W-1:0]  atan_s;
  logic signed [17:0]                neg_rate;
  logic signed [17:0]                w_comp;
  logic signed [25:0]                err_diff;
  logic signed [25:0]                ang_mag;
  logic signed [tbpd_pkg::SUM_W-1:0] sum_all;
  logic signed [tbpd_pkg::RND_W-1:0] rnd_val;
  logic signed [tbpd_pkg::RND_W-1:0] lim_pos;
  logic signed [tbpd_pkg::SAT_W-1:0] a1_sum;
  logic                              in_acc;
  logic                              out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == tbpd_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, tilt_r, drive_r};
  assign out_tuser  = upright_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_offset_r  <= '0;
      gyro_scale_r   <= 24'd261122;
      blend_weight_r <= 16'd65274;
      prop_gain_r    <= 16'd2458;
      deriv_gain_r   <= 16'd205;
      tilt_limit_r   <= 24'd655360;
      drive_limit_r  <= 17'd49152;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tbpd_pkg::reg_idx_t'(cfg_index))
        tbpd_pkg::REG_GYRO_OFFSET:  gyro_offset_r  <= cfg_data[15:0];
        tbpd_pkg::REG_GYRO_SCALE:   gyro_scale_r   <= cfg_data;
        tbpd_pkg::REG_BLEND_WEIGHT: blend_weight_r <= cfg_data[15:0];
        tbpd_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_data[15:0];
        tbpd_pkg::REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[15:0];
        tbpd_pkg::REG_TILT_LIMIT:   tilt_limit_r   <= cfg_data;
        tbpd_pkg::REG_DRIVE_LIMIT:  drive_limit_r  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // sample unpacking and cordic start vector
  always_comb begin
    in_ay = {in_tdata[15], in_tdata[15:0]};
    in_az = {in_tdata[31], in_tdata[31:16]};
    in_x0 = -in_az;
    cx0   = in_x0;
    cy0   = in_ay;
    if (in_x0[16]) begin
      cx0 = in_az;
      cy0 = -in_ay;
    end
  end

  // cordic shift terms and table angle
  assign sx     = cx_r >>> cnt_r;
  assign sy     = cy_r >>> cnt_r;
  assign atan_s = tbpd_pkg::CZ_W'(tbpd_pkg::atan_deg(cnt_r));

  // operand helpers
  assign neg_rate = -{rate_r[16], rate_r};
  assign w_comp   = 18'sd65536 - $signed({2'b0, blend_weight_r});
  assign err_diff = {angle_r[24], angle_r} - {last_err_r[24], last_err_r};
  assign ang_mag  = angle_r[24] ? -{angle_r[24], angle_r} : {angle_r[24], angle_r};

  // accumulation and rounding after the multiplier
  assign sum_all = {sum_r[tbpd_pkg::PROD_W-1], sum_r}
                 + {prod_r[tbpd_pkg::PROD_W-1], prod_r};
  assign rnd_val = tbpd_pkg::rnd16(sum_all);
  assign a1_sum  = tbpd_pkg::SAT_W'(est_r)
                 + tbpd_pkg::SAT_W'(tbpd_pkg::rnd16(
                     {prod_r[tbpd_pkg::PROD_W-1], prod_r}));
  assign lim_pos = $signed({{(tbpd_pkg::RND_W-17){1'b0}}, drive_limit_r});

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      tbpd_pkg::ST_MGYRO: begin
        mul_a = tbpd_pkg::MA_W'(neg_rate);
        mul_b = $signed({1'b0, gyro_scale_r});
      end
      tbpd_pkg::ST_MBW: begin
        mul_a = tbpd_pkg::MA_W'(a1_r);
        mul_b = tbpd_pkg::MB_W'($signed({1'b0, blend_weight_r}));
      end
      tbpd_pkg::ST_MBA: begin
        mul_a = zero_r ? '0 : cz_r;
        mul_b = tbpd_pkg::MB_W'(w_comp);
      end
      tbpd_pkg::ST_MP: begin
        mul_a = tbpd_pkg::MA_W'(angle_r);
        mul_b = tbpd_pkg::MB_W'($signed({1'b0, prop_gain_r}));
      end
      tbpd_pkg::ST_MD: begin
        mul_a = err_diff;
        mul_b = tbpd_pkg::MB_W'($signed({1'b0, deriv_gain_r}));
      end
      default: ;
    endcase
  end

  // sequencer next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rate_nxt      = rate_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    zero_nxt      = zero_r;
    a1_nxt        = a1_r;
    angle_nxt     = angle_r;
    est_nxt       = est_r;
    last_err_nxt  = last_err_r;
    up_nxt        = up_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    drive_nxt     = drive_r;
    tilt_nxt      = tilt_r;
    upright_nxt   = upright_r;

    unique case (state_r)
      // take a sample and set up the vectoring start point
      tbpd_pkg::ST_IDLE: begin
        if (in_acc) begin
          rate_nxt  = {in_tdata[47], in_tdata[47:32]} - {gyro_offset_r[15], gyro_offset_r};
          cx_nxt    = $signed({{3{cx0[16]}}, cx0, 8'b0});
          cy_nxt    = $signed({{3{cy0[16]}}, cy0, 8'b0});
          if (in_x0[16]) begin
            cz_nxt = in_ay[16] ? -tbpd_pkg::DEG180 : tbpd_pkg::DEG180;
          end else begin
            cz_nxt = '0;
          end
          zero_nxt  = (in_tdata[31:0] == 32'd0);
          cnt_nxt   = '0;
          state_nxt = tbpd_pkg::ST_CORDIC;
        end
      end
      // one vectoring rotation per cycle
      tbpd_pkg::ST_CORDIC: begin
        if (!cy_r[tbpd_pkg::CXY_W-1]) begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          cz_nxt = cz_r + atan_s;
        end else begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          cz_nxt = cz_r - atan_s;
        end
        if (cnt_r == tbpd_pkg::CNT_W'(tbpd_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = tbpd_pkg::ST_MGYRO;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // gyro increment product
      tbpd_pkg::ST_MGYRO: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = tbpd_pkg::ST_A1;
      end
      // integrate into the kept angle
      tbpd_pkg::ST_A1: begin
        a1_nxt    = tbpd_pkg::sat25(a1_sum);
        state_nxt = tbpd_pkg::ST_MBW;
      end
      // gyro side of the blend
      tbpd_pkg::ST_MBW: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = tbpd_pkg::ST_MBA;
      end
      // accelerometer side of the blend
      tbpd_pkg::ST_MBA: begin
        sum_nxt   = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = tbpd_pkg::ST_ANG;
      end
      // blended angle becomes the new estimate
      tbpd_pkg::ST_ANG: begin
        angle_nxt = tbpd_pkg::sat25(tbpd_pkg::SAT_W'(rnd_val));
        est_nxt   = angle_nxt;
        state_nxt = tbpd_pkg::ST_MP;
      end
      // proportional term and tilt check
      tbpd_pkg::ST_MP: begin
        prod_nxt  = mul_a * mul_b;
        up_nxt    = (ang_mag <= $signed({2'b0, tilt_limit_r}));
        state_nxt = tbpd_pkg::ST_MD;
      end
      // derivative term
      tbpd_pkg::ST_MD: begin
        sum_nxt   = prod_r;
        prod_nxt  = mul_a * mul_b;
        state_nxt = tbpd_pkg::ST_DRV;
      end
      // clamp the drive and hand the result over
      tbpd_pkg::ST_DRV: begin
        if (out_free) begin
          if (!up_r) begin
            drive_nxt = '0;
          end else if (rnd_val > lim_pos) begin
            drive_nxt = lim_pos[17:0];
          end else if (rnd_val < -lim_pos) begin
            drive_nxt = 18'(-lim_pos);
          end else begin
            drive_nxt = rnd_val[17:0];
          end
          if (up_r) begin
            last_err_nxt = angle_r;
          end
          tilt_nxt      = angle_r;
          upright_nxt   = up_r;
          out_valid_nxt = 1'b1;
          state_nxt     = tbpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbpd_pkg::ST_IDLE;
    endcase
  end

  // control state and kept filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbpd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      est_r       <= '0;
      last_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      last_err_r  <= last_err_nxt;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    rate_r    <= rate_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    zero_r    <= zero_nxt;
    a1_r      <= a1_nxt;
    angle_r   <= angle_nxt;
    up_r      <= up_nxt;
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    drive_r   <= drive_nxt;
    tilt_r    <= tilt_nxt;
    upright_r <= upright_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/tbpd_checker.sv
// ---------------------------------------------------------------------------
// tbpd_checker
// port-level checks of the tilt balance controller, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "tilt_balance_pd_controller_defines.svh"

module tbpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // a fallen result carries no drive
  `TBPD_ASSERT_IMP(a_fallen_no_drive, out_tvalid && !out_tuser, out_tdata[17:0] == 18'd0, "drive not zero while fallen")

  // the sequencer is busy once a sample transaction is taken
  `TBPD_ASSERT_NXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "ready right after a sample transaction")

  // no result can appear the cycle after a sample is taken
  `TBPD_ASSERT_NXT(a_no_instant_result, in_tvalid && in_tready, !$rose(out_tvalid), "result too early")

  // a stalled result holds
  `TBPD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind tilt_balance_pd_controller tbpd_checker u_tbpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: dv/tilt_balance_pd_controller_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_balance_pd_controller_checker
// watches the register, sample and result channels, keeps its own copy of
// the filter state and settings, and compares every result with its forecast
// ---------------------------------------------------------------------------

module tilt_balance_pd_controller_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  input  wire logic        out_tuser,
  output int               fault_total,
  output int               outstanding
);

  typedef struct packed {
    logic signed [17:0] drive;
    logic signed [24:0] tilt;
    logic               upright;
  } control_t;

  localparam longint ANGLE_HI  = 16777215;
  localparam longint ANGLE_LO  = -16777216;
  localparam longint HALF_TURN = 11796480;
  localparam int     XY_PRESHIFT = 8;

  // arctangent of 2^-i in q9.16 degrees
  localparam longint ARCTAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // settings as the block should hold them
  longint bias_r, scale_r, weight_r, kp_r, kd_r, tilt_lim_r, drive_lim_r;
  // filter state
  longint angle_est, prev_err;

  control_t expected_ctrl_q [$];
  int       fault_n = 0;

  assign fault_total = fault_n;
  assign outstanding = expected_ctrl_q.size();

  // product scaling with round half up
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_angle(input longint v);
    if (v > ANGLE_HI) return ANGLE_HI;
    if (v < ANGLE_LO) return ANGLE_LO;
    return v;
  endfunction

  // vectoring cordic, angle of (x, y) in q9.16 degrees
  function automatic longint accel_angle(input longint y_in, input longint x_in);
    longint x, y, z, nx, ny;
    int     n;
    x = x_in;
    y = y_in;
    z = 0;
    n = (tbpd_pkg::CORDIC_STEPS > 24) ? 24 : tbpd_pkg::CORDIC_STEPS;
    if (x == 0 && y == 0) return 0;
    // left half plane: turn by half a revolution first
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    x = x <<< XY_PRESHIFT;
    y = y <<< XY_PRESHIFT;
    for (int i = 0; i < n; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ARCTAN_DEG[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ARCTAN_DEG[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // one sample through the filter and the pd stage, state updated in place
  function automatic control_t predict_control(input logic [47:0] sample);
    longint   lat, vert, gyro, rate, a1, acc, ang, mag, pd, drv;
    control_t r;
    lat  = longint'($signed(sample[15:0]));
    vert = longint'($signed(sample[31:16]));
    gyro = longint'($signed(sample[47:32]));
    rate = gyro - bias_r;
    a1   = clip_angle(angle_est + round_shift(-rate * scale_r, 16));
    acc  = accel_angle(lat, -vert);
    ang  = clip_angle(round_shift(a1 * weight_r + acc * (65536 - weight_r), 16));
    angle_est = ang;
    drv = 0;
    r.upright = 1'b0;
    mag = (ang < 0) ? -ang : ang;
    // pd only while upright, otherwise the error memory is kept
    if (mag <= tilt_lim_r) begin
      pd  = kp_r * ang + kd_r * (ang - prev_err);
      drv = round_shift(pd, 16);
      if (drv > drive_lim_r)  drv = drive_lim_r;
      if (drv < -drive_lim_r) drv = -drive_lim_r;
      prev_err  = ang;
      r.upright = 1'b1;
    end
    r.drive = 18'(drv);
    r.tilt  = 25'(ang);
    return r;
  endfunction

  function automatic void note_fault(input string msg);
    fault_n++;
    if (fault_n <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // channel monitor
  always @(posedge clk) begin
    control_t got, want;
    if (!rst_n) begin
      bias_r      = 0;
      scale_r     = 261122;
      weight_r    = 65274;
      kp_r        = 2458;
      kd_r        = 205;
      tilt_lim_r  = 655360;
      drive_lim_r = 49152;
      angle_est   = 0;
      prev_err    = 0;
      expected_ctrl_q.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tbpd_pkg::REG_GYRO_OFFSET:  bias_r      = longint'($signed(cfg_data[15:0]));
          tbpd_pkg::REG_GYRO_SCALE:   scale_r     = longint'(cfg_data);
          tbpd_pkg::REG_BLEND_WEIGHT: weight_r    = longint'(cfg_data[15:0]);
          tbpd_pkg::REG_PROP_GAIN:    kp_r        = longint'(cfg_data[15:0]);
          tbpd_pkg::REG_DERIV_GAIN:   kd_r        = longint'(cfg_data[15:0]);
          tbpd_pkg::REG_TILT_LIMIT:   tilt_lim_r  = longint'(cfg_data);
          tbpd_pkg::REG_DRIVE_LIMIT:  drive_lim_r = longint'(cfg_data[16:0]);
          default: ;
        endcase
      end
      // sample transaction
      if (in_tvalid && in_tready) expected_ctrl_q.push_back(predict_control(in_tdata));
      // result transaction
      if (out_tvalid && out_tready) begin
        got.drive   = out_tdata[17:0];
        got.tilt    = out_tdata[42:18];
        got.upright = out_tuser;
        if (expected_ctrl_q.size() == 0) begin
          note_fault($sformatf("unexpected result: drive %0d tilt %0d upright %0b",
                               got.drive, got.tilt, got.upright));
        end else begin
          want = expected_ctrl_q.pop_front();
          if (got.drive !== want.drive || got.tilt !== want.tilt ||
              got.upright !== want.upright) begin
            note_fault($sformatf(
              "mismatch: drive exp %0d got %0d, tilt exp %0d got %0d, upright exp %0b got %0b",
              want.drive, got.drive, want.tilt, got.tilt, want.upright, got.upright));
          end
        end
      end
    end
  end

endmodule

FILE: dv/tilt_balance_pd_controller_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_balance_pd_controller_test
// drives imu samples and register settings into the controller under random
// source gaps and sink stalls; the checker beside it judges every result
// ---------------------------------------------------------------------------

module tilt_balance_pd_controller_test;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  // settings profiles
  localparam int CFG_NOMINAL = 0;
  localparam int CFG_TOP     = 1;
  localparam int CFG_BOTTOM  = 2;
  localparam int CFG_SCATTER = 3;
  localparam int PHASES      = 6;
  localparam int PHASE_PLAN [PHASES] = '{
    CFG_NOMINAL, CFG_SCATTER, CFG_NOMINAL, CFG_TOP, CFG_NOMINAL, CFG_BOTTOM
  };
  localparam int PHASE_ITEMS    = 250;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int QUIET_LIMIT    = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // accel_lateral, accel_vertical, roll_rate
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // drive, tilt_angle, zero padding
  logic        out_tuser;  // upright

  int fault_total;
  int outstanding;
  int sender_idle_pct = 0;
  int rx_stall_pct    = 0;
  int gyro_bias       = 0;
  int quiet_cycles    = 0;
  bit squeeze_req     = 1'b0;

  tilt_balance_pd_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tilt_balance_pd_controller_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fault_total (fault_total),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_sample(input int lat, input int vert, input int gyro);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {16'(gyro), 16'(vert), 16'(lat)};
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly a near-level rig with small rates, plus inverted and raw noise
  task automatic send_random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_sample(int'($urandom_range(6000)) - 3000,
                  -16384 + int'($urandom_range(1000)) - 500,
                  gyro_bias + int'($urandom_range(600)) - 300);
    end else if (pick < 80) begin
      send_sample(int'($urandom), int'($urandom_range(32767)), int'($urandom));
    end else if (pick < 83) begin
      send_sample(0, 0, int'($urandom));
    end else begin
      send_sample(int'($urandom), int'($urandom), int'($urandom));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait until every forecast result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic program_regs(input int profile);
    logic [23:0] v_off, v_scale, v_weight, v_kp, v_kd, v_tilt, v_drive;
    wait_drained();
    case (profile)
      CFG_TOP: begin
        v_off    = 24'($urandom);
        v_scale  = 24'hFFFFFF;
        v_weight = {8'($urandom), 16'hFFFF};
        v_kp     = {8'($urandom), 16'hFFFF};
        v_kd     = {8'($urandom), 16'hFFFF};
        v_tilt   = $urandom_range(1) ? 24'd11796480 : 24'hFFFFFF;
        v_drive  = {7'($urandom), 17'h1FFFF};
      end
      CFG_BOTTOM: begin
        v_off    = {8'($urandom), 16'h8000};
        v_scale  = 24'd0;
        v_weight = {8'($urandom), 16'h0000};
        v_kp     = 24'd0;
        v_kd     = 24'd0;
        v_tilt   = 24'd0;
        v_drive  = {7'($urandom), 17'd0};
      end
      CFG_SCATTER: begin
        v_off    = 24'($urandom);
        v_scale  = 24'($urandom);
        v_weight = 24'($urandom);
        v_kp     = 24'($urandom);
        v_kd     = 24'($urandom);
        v_tilt   = 24'($urandom);
        v_drive  = 24'($urandom);
      end
      default: begin
        v_off    = {8'($urandom), 16'(int'($urandom_range(400)) - 200)};
        v_scale  = 24'($urandom_range(300000, 200000));
        v_weight = {8'($urandom), 16'($urandom_range(65535, 60000))};
        v_kp     = {8'($urandom), 16'($urandom_range(8000))};
        v_kd     = {8'($urandom), 16'($urandom_range(2000))};
        v_tilt   = 24'($urandom_range(40 * 65536, 5 * 65536));
        v_drive  = {7'($urandom), 17'($urandom_range(131071, 4096))};
      end
    endcase
    gyro_bias = int'($signed(v_off[15:0]));
    write_reg(tbpd_pkg::REG_GYRO_OFFSET,  v_off);
    write_reg(tbpd_pkg::REG_GYRO_SCALE,   v_scale);
    write_reg(tbpd_pkg::REG_BLEND_WEIGHT, v_weight);
    write_reg(tbpd_pkg::REG_PROP_GAIN,    v_kp);
    write_reg(tbpd_pkg::REG_DERIV_GAIN,   v_kd);
    write_reg(tbpd_pkg::REG_TILT_LIMIT,   v_tilt);
    write_reg(tbpd_pkg::REG_DRIVE_LIMIT,  v_drive);
    // unused index must leave every setting alone
    write_reg(REG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero vector, level, 45 degrees, inverted and full scale
    send_sample(0, 0, 0);
    send_sample(0, -16384, 0);
    send_sample(16384, -16384, 0);
    send_sample(0, 16384, 0);
    send_sample(200, 16384, 0);
    send_sample(-200, 16384, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, 0);
    send_sample(32767, -32768, 0);
    send_sample(0, -32768, -32768);

    // largest settings, rate pushes the angle into negative saturation
    program_regs(CFG_TOP);
    wait_drained();
    write_reg(tbpd_pkg::REG_GYRO_OFFSET, 24'hA58000);
    cfg_valid <= 1'b0;
    gyro_bias = -32768;
    repeat (3) send_sample(0, -16384, 32767);
    // and then into positive saturation
    wait_drained();
    write_reg(tbpd_pkg::REG_GYRO_OFFSET, 24'h5A7FFF);
    cfg_valid <= 1'b0;
    gyro_bias = 32767;
    repeat (4) send_sample(0, -16384, -32768);

    // smallest settings: all at zero, including both limits, but the gyro offset at -32768
    program_regs(CFG_BOTTOM);
    send_sample(0, 0, 0);
    send_sample(100, -100, 5);
    send_sample(-5, 16384, 0);

    // random phases under changing settings and flow control
    for (int p = 0; p < PHASES; p++) begin
      program_regs(PHASE_PLAN[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin sender_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      if (p == 0) squeeze_req = 1'b1;
      repeat (PHASE_ITEMS) send_random_sample();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fault_total == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
